FILE: rtl/text_glyph_page_blitter_core_assert.svh
// Assertion macros used by the checker file of the glyph page blitter.
// Depends on nothing; included by bare file name.
`ifndef TEXT_GLYPH_PAGE_BLITTER_CORE_ASSERT_SVH
`define TEXT_GLYPH_PAGE_BLITTER_CORE_ASSERT_SVH

// same-cycle implication
`define TGPB_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgpb assertion failed");

// next-cycle implication
`define TGPB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgpb assertion failed");

`endif

FILE: rtl/tgpb_pkg.sv
// Package of the glyph page blitter: page geometry, codes, font ROM,
// controller/datapath interface types. No dependencies.
`timescale 1ns / 1ps

package tgpb_pkg;

    localparam int PAGE_SIDE   = 60;
    localparam int GLYPH_COUNT = 27;
    localparam int GLYPH_ROWS  = 5;
    localparam int GLYPH_COLS  = 6;
    localparam int PAGE_DEPTH  = PAGE_SIDE * PAGE_SIDE;
    localparam int ADDR_W      = $clog2(PAGE_DEPTH);
    localparam int POS_W       = $clog2(PAGE_SIDE);
    localparam int COORD_W     = 11;
    localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
    localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
    localparam int FONT_AW     = $clog2(FONT_DEPTH);
    localparam int ROW_CNT_W   = $clog2(GLYPH_ROWS);
    localparam int COL_CNT_W   = $clog2(GLYPH_COLS);

    localparam logic [1:0] OP_PLACE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ALIGN_LEFT   = 2'd0;
    localparam logic [1:0] ALIGN_RIGHT  = 2'd1;
    localparam logic [1:0] ALIGN_CENTER = 2'd2;
    localparam logic [1:0] ALIGN_ABS    = 2'd3;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_A     = 7'h41;
    localparam logic [6:0] CHAR_Z     = 7'h5A;

    localparam logic [GLYPH_W-1:0] GLYPH_BLANK = GLYPH_W'(GLYPH_COUNT - 1);

    localparam logic [5:0] FONT_ROM [FONT_DEPTH] = '{
        6'h1C,6'h22,6'h3E,6'h22,6'h22, 6'h3C,6'h22,6'h3C,6'h22,6'h3C,
        6'h1E,6'h22,6'h20,6'h20,6'h1E, 6'h3C,6'h22,6'h22,6'h22,6'h3C,
        6'h3E,6'h20,6'h38,6'h20,6'h3E, 6'h3E,6'h20,6'h38,6'h20,6'h20,
        6'h1E,6'h20,6'h26,6'h22,6'h1C, 6'h22,6'h22,6'h3E,6'h22,6'h22,
        6'h3E,6'h08,6'h08,6'h08,6'h3E, 6'h0E,6'h04,6'h04,6'h24,6'h18,
        6'h22,6'h24,6'h38,6'h24,6'h22, 6'h20,6'h20,6'h20,6'h20,6'h3E,
        6'h22,6'h36,6'h2A,6'h22,6'h22, 6'h22,6'h32,6'h2A,6'h26,6'h22,
        6'h1C,6'h22,6'h22,6'h22,6'h1C, 6'h3C,6'h22,6'h3C,6'h20,6'h20,
        6'h1C,6'h22,6'h22,6'h26,6'h1E, 6'h3C,6'h22,6'h3C,6'h24,6'h22,
        6'h1E,6'h20,6'h1C,6'h02,6'h3C, 6'h3E,6'h2A,6'h08,6'h08,6'h1C,
        6'h22,6'h22,6'h22,6'h22,6'h1C, 6'h22,6'h22,6'h14,6'h14,6'h08,
        6'h22,6'h22,6'h2A,6'h36,6'h22, 6'h22,6'h14,6'h08,6'h14,6'h22,
        6'h22,6'h14,6'h08,6'h08,6'h08, 6'h3E,6'h04,6'h08,6'h10,6'h3E,
        6'h00,6'h00,6'h00,6'h00,6'h00
    };

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_DRAW,
        ST_RDATA
    } state_t;

    typedef struct packed {
        logic load;
        logic sweep_step;
        logic draw_step;
        logic small_write;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       big;
        logic       glyph_ok;
        logic       sweep_done;
        logic       draw_done;
        logic       out_free;
    } ctrl_status_t;

    function automatic logic [5:0] font_row(input logic [GLYPH_W-1:0] glyph,
                                            input logic [ROW_CNT_W-1:0] line);
        logic [FONT_AW-1:0] idx;
        idx = FONT_AW'(glyph) * FONT_AW'(GLYPH_ROWS) + FONT_AW'(line);
        return FONT_ROM[idx];
    endfunction

endpackage

FILE: rtl/text_glyph_page_blitter_core.sv
// Glyph page blitter: a 60x60 page of character cells in one byte-wide memory,
// written by place requests, read by read requests, refilled by clear requests.
// After reset and after every clear request the page is swept to '.' at one
// cell per cycle, during which no request is taken. A small-font place is
// accept then decode; a big-font place adds thirty pixel steps through the
// single write port of the page memory (not for non-glyph characters); a read
// adds a data state that waits for the output register, a clear the sweep.
// One request is in work at a time; a read result waits in an output
// register while the next request is accepted.
`timescale 1ns / 1ps

module text_glyph_page_blitter_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic       big_font,
    input  logic [1:0] align,
    input  logic [5:0] row,
    input  logic [5:0] column,
    input  logic [5:0] text_length,
    input  logic [5:0] char_index,
    input  logic [6:0] char_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] cell_char
);

    tgpb_pkg::ctrl_cmd_t    cmd;
    tgpb_pkg::ctrl_status_t status;

    tgpb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tgpb_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .opcode      (opcode),
        .big_font    (big_font),
        .align       (align),
        .row         (row),
        .column      (column),
        .text_length (text_length),
        .char_index  (char_index),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_char   (cell_char),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

FILE: rtl/tgpb_ctrl.sv
// Controller of the glyph page blitter: request sequencing state machine.
// Depends on tgpb_pkg.
`timescale 1ns / 1ps

module tgpb_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tgpb_pkg::ctrl_status_t status,
    output tgpb_pkg::ctrl_cmd_t    cmd
);

    tgpb_pkg::state_t state_reg;
    tgpb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tgpb_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tgpb_pkg::ST_CLEAR:
            begin
                if (status.sweep_done)
                begin
                    state_next = tgpb_pkg::ST_IDLE;
                end
            end
            tgpb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tgpb_pkg::ST_DECODE;
                end
            end
            tgpb_pkg::ST_DECODE:
            begin
                case (status.op)
                    tgpb_pkg::OP_READ:  state_next = tgpb_pkg::ST_RDATA;
                    tgpb_pkg::OP_CLEAR: state_next = tgpb_pkg::ST_CLEAR;
                    tgpb_pkg::OP_PLACE:
                    begin
                        if (status.big && status.glyph_ok)
                        begin
                            state_next = tgpb_pkg::ST_DRAW;
                        end
                        else
                        begin
                            state_next = tgpb_pkg::ST_IDLE;
                        end
                    end
                    default: state_next = tgpb_pkg::ST_IDLE;
                endcase
            end
            tgpb_pkg::ST_DRAW:
            begin
                if (status.draw_done)
                begin
                    state_next = tgpb_pkg::ST_IDLE;
                end
            end
            tgpb_pkg::ST_RDATA:
            begin
                if (status.out_free)
                begin
                    state_next = tgpb_pkg::ST_IDLE;
                end
            end
            default: state_next = tgpb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            tgpb_pkg::ST_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
            end
            tgpb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            tgpb_pkg::ST_DECODE:
            begin
                cmd.small_write = (status.op == tgpb_pkg::OP_PLACE) && !status.big;
            end
            tgpb_pkg::ST_DRAW:
            begin
                cmd.draw_step = 1'b1;
            end
            tgpb_pkg::ST_RDATA:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/tgpb_datapath.sv
// Datapath of the glyph page blitter: request latch, placement math,
// page memory, glyph counters and output register. Depends on tgpb_pkg.
`timescale 1ns / 1ps

module tgpb_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             opcode,
    input  logic                   big_font,
    input  logic [1:0]             align,
    input  logic [5:0]             row,
    input  logic [5:0]             column,
    input  logic [5:0]             text_length,
    input  logic [5:0]             char_index,
    input  logic [6:0]             char_code,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             cell_char,
    input  tgpb_pkg::ctrl_cmd_t     cmd,
    output tgpb_pkg::ctrl_status_t  status
);

    logic [7:0] page_mem [tgpb_pkg::PAGE_DEPTH];

    // latched request
    logic [1:0]                      op_reg;
    logic                            big_reg;
    logic [6:0]                      ch_reg;
    tgpb_pkg::coord_t                row0_reg;
    tgpb_pkg::coord_t                base_reg;
    logic [tgpb_pkg::GLYPH_W-1:0]    glyph_reg;
    logic                            glyph_ok_reg;
    logic                            rd_ok_reg;
    tgpb_pkg::addr_t                 rd_addr_reg;
    logic [7:0]                      rdata_reg;

    logic [tgpb_pkg::GLYPH_W-1:0]    glyph_next;
    logic                            glyph_ok_next;
    logic                            rd_ok_next;
    tgpb_pkg::addr_t                 rd_addr_next;
    tgpb_pkg::coord_t                base_next;

    // counters
    tgpb_pkg::addr_t                 sweep_reg;
    tgpb_pkg::addr_t                 sweep_next;
    logic [tgpb_pkg::ROW_CNT_W-1:0]  line_reg;
    logic [tgpb_pkg::ROW_CNT_W-1:0]  line_next;
    logic [tgpb_pkg::COL_CNT_W-1:0]  dot_reg;
    logic [tgpb_pkg::COL_CNT_W-1:0]  dot_next;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [7:0]                      cell_char_reg;
    logic [7:0]                      cell_char_next;

    tgpb_pkg::coord_t row_c;
    tgpb_pkg::coord_t col_c;
    tgpb_pkg::coord_t len_c;
    tgpb_pkg::coord_t idx_c;
    tgpb_pkg::coord_t side_c;
    tgpb_pkg::coord_t row0_c;
    tgpb_pkg::coord_t colm1_c;

    tgpb_pkg::coord_t cur_r;
    tgpb_pkg::coord_t cur_c;
    logic             in_page;
    tgpb_pkg::addr_t  cur_addr;
    logic [5:0]       font_bits;
    logic             pixel;
    logic             sweep_done;
    logic             draw_done;

    logic             mem_we;
    tgpb_pkg::addr_t  mem_waddr;
    logic [7:0]       mem_wdata;

    // placement math on the incoming request
    assign row_c   = tgpb_pkg::coord_t'(row);
    assign col_c   = tgpb_pkg::coord_t'(column);
    assign len_c   = tgpb_pkg::coord_t'(text_length);
    assign idx_c   = tgpb_pkg::coord_t'(char_index);
    assign side_c  = tgpb_pkg::coord_t'(tgpb_pkg::PAGE_SIDE);
    assign row0_c  = row_c - tgpb_pkg::coord_t'(1);
    assign colm1_c = col_c - tgpb_pkg::coord_t'(1);

    always_comb
    begin
        base_next = '0;
        if (!big_font)
        begin
            case (align)
                tgpb_pkg::ALIGN_LEFT:   base_next = '0;
                tgpb_pkg::ALIGN_RIGHT:  base_next = side_c - len_c;
                tgpb_pkg::ALIGN_CENTER: base_next = (side_c >>> 1) - (len_c >>> 1);
                tgpb_pkg::ALIGN_ABS:    base_next = colm1_c;
                default:                base_next = '0;
            endcase
            base_next = base_next + idx_c;
        end
        else
        begin
            case (align)
                tgpb_pkg::ALIGN_LEFT:   base_next = '0;
                tgpb_pkg::ALIGN_RIGHT:  base_next = side_c - len_c * tgpb_pkg::coord_t'(6);
                tgpb_pkg::ALIGN_CENTER:
                    base_next = (side_c >>> 1) - len_c * tgpb_pkg::coord_t'(3);
                tgpb_pkg::ALIGN_ABS:    base_next = colm1_c;
                default:                base_next = '0;
            endcase
            base_next = base_next + idx_c * tgpb_pkg::coord_t'(tgpb_pkg::GLYPH_COLS);
        end
    end

    always_comb
    begin
        glyph_next    = '0;
        glyph_ok_next = 1'b0;
        if (char_code >= tgpb_pkg::CHAR_A && char_code <= tgpb_pkg::CHAR_Z)
        begin
            glyph_next    = tgpb_pkg::GLYPH_W'(char_code - tgpb_pkg::CHAR_A);
            glyph_ok_next = 1'b1;
        end
        else if (char_code == tgpb_pkg::CHAR_SPACE)
        begin
            glyph_next    = tgpb_pkg::GLYPH_BLANK;
            glyph_ok_next = 1'b1;
        end
    end

    assign rd_ok_next = (row_c >= tgpb_pkg::coord_t'(1)) && (row_c <= side_c)
                     && (col_c >= tgpb_pkg::coord_t'(1)) && (col_c <= side_c);
    assign rd_addr_next = tgpb_pkg::addr_t'(row0_c[tgpb_pkg::POS_W-1:0])
                        * tgpb_pkg::addr_t'(tgpb_pkg::PAGE_SIDE)
                        + tgpb_pkg::addr_t'(colm1_c[tgpb_pkg::POS_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= opcode;
            big_reg      <= big_font;
            ch_reg       <= char_code;
            row0_reg     <= row0_c;
            base_reg     <= base_next;
            glyph_reg    <= glyph_next;
            glyph_ok_reg <= glyph_ok_next;
            rd_ok_reg    <= rd_ok_next;
            rd_addr_reg  <= rd_addr_next;
        end
    end

    // current cell; counters sit at zero outside a glyph draw
    assign cur_r    = row0_reg + tgpb_pkg::coord_t'(line_reg);
    assign cur_c    = base_reg + tgpb_pkg::coord_t'(dot_reg);
    assign in_page  = (cur_r >= tgpb_pkg::coord_t'(0)) && (cur_r < side_c)
                   && (cur_c >= tgpb_pkg::coord_t'(0)) && (cur_c < side_c);
    assign cur_addr = tgpb_pkg::addr_t'(cur_r[tgpb_pkg::POS_W-1:0])
                    * tgpb_pkg::addr_t'(tgpb_pkg::PAGE_SIDE)
                    + tgpb_pkg::addr_t'(cur_c[tgpb_pkg::POS_W-1:0]);

    assign font_bits = tgpb_pkg::font_row(glyph_reg, line_reg);
    assign pixel     = font_bits[tgpb_pkg::COL_CNT_W'(tgpb_pkg::GLYPH_COLS - 1) - dot_reg];

    assign sweep_done = (sweep_reg == tgpb_pkg::addr_t'(tgpb_pkg::PAGE_DEPTH - 1));
    assign draw_done  = (line_reg == tgpb_pkg::ROW_CNT_W'(tgpb_pkg::GLYPH_ROWS - 1))
                     && (dot_reg == tgpb_pkg::COL_CNT_W'(tgpb_pkg::GLYPH_COLS - 1));

    always_comb
    begin
        sweep_next = sweep_reg;
        line_next  = line_reg;
        dot_next   = dot_reg;
        if (cmd.sweep_step)
        begin
            sweep_next = sweep_done ? '0 : sweep_reg + tgpb_pkg::addr_t'(1);
        end
        if (cmd.draw_step)
        begin
            if (dot_reg == tgpb_pkg::COL_CNT_W'(tgpb_pkg::GLYPH_COLS - 1))
            begin
                dot_next  = '0;
                line_next = draw_done ? '0 : line_reg + tgpb_pkg::ROW_CNT_W'(1);
            end
            else
            begin
                dot_next = dot_reg + tgpb_pkg::COL_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            line_reg      <= '0;
            dot_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sweep_reg     <= sweep_next;
            line_reg      <= line_next;
            dot_reg       <= dot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // single write port: sweep, glyph pixel or small character
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = tgpb_pkg::CHAR_STAR;
        if (cmd.sweep_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = tgpb_pkg::CHAR_DOT;
        end
        else if (cmd.draw_step)
        begin
            mem_we = pixel && in_page;
        end
        else if (cmd.small_write)
        begin
            mem_we    = in_page && (ch_reg != tgpb_pkg::CHAR_SPACE);
            mem_wdata = {1'b0, ch_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= page_mem[rd_addr_reg];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        cell_char_next = cell_char_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            cell_char_next = rd_ok_reg ? rdata_reg : 8'h00;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_char_reg <= cell_char_next;
    end

    assign out_valid = out_valid_reg;
    assign cell_char = cell_char_reg;

    always_comb
    begin
        status.op         = op_reg;
        status.big        = big_reg;
        status.glyph_ok   = glyph_ok_reg;
        status.sweep_done = sweep_done;
        status.draw_done  = draw_done;
        status.out_free   = !out_valid_reg || out_ready;
    end

endmodule

FILE: rtl/tgpb_checker.sv
// Port-level checker of the glyph page blitter, bound to the top level.
// Depends on tgpb_pkg and text_glyph_page_blitter_core_assert.svh.
`timescale 1ns / 1ps
`include "text_glyph_page_blitter_core_assert.svh"

module tgpb_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] opcode,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] cell_char
);

    // a waiting result holds
    `TGPB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(cell_char))

    // one request in work: busy right after an accept
    `TGPB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // a result appears only while a request is in work
    `TGPB_ASSERT_NOW(a_out_from_work, clk, rst_n, $rose(out_valid), !$past(in_ready))

    // a read keeps the input side closed for its data cycle
    `TGPB_ASSERT_NEXT(a_read_busy, clk, rst_n, in_valid && in_ready && opcode == tgpb_pkg::OP_READ, ##1 !in_ready)

endmodule

bind text_glyph_page_blitter_core tgpb_checker u_tgpb_checker (.*);

FILE: dv/text_glyph_page_blitter_core_tb.sv
// Testbench for text_glyph_page_blitter_core: directed and random place, read and clear
// requests, each read result checked against a page predictor kept here.
// Depends on tgpb_pkg and the core RTL only.
`timescale 1ns / 1ps

module text_glyph_page_blitter_core_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 64;
    localparam int RANDOM_ITEMS = 1800;

    typedef struct packed {
        logic [1:0] opcode;
        logic       big_font;
        logic [1:0] align;
        logic [5:0] row;
        logic [5:0] column;
        logic [5:0] text_length;
        logic [5:0] char_index;
        logic [6:0] char_code;
    } page_req_t;

    // A..Z then blank; bit 5 is the leftmost pixel
    localparam logic [5:0] GLYPH_BITS [tgpb_pkg::GLYPH_COUNT*tgpb_pkg::GLYPH_ROWS] = '{
        6'h1C,6'h22,6'h3E,6'h22,6'h22, 6'h3C,6'h22,6'h3C,6'h22,6'h3C,
        6'h1E,6'h22,6'h20,6'h20,6'h1E, 6'h3C,6'h22,6'h22,6'h22,6'h3C,
        6'h3E,6'h20,6'h38,6'h20,6'h3E, 6'h3E,6'h20,6'h38,6'h20,6'h20,
        6'h1E,6'h20,6'h26,6'h22,6'h1C, 6'h22,6'h22,6'h3E,6'h22,6'h22,
        6'h3E,6'h08,6'h08,6'h08,6'h3E, 6'h0E,6'h04,6'h04,6'h24,6'h18,
        6'h22,6'h24,6'h38,6'h24,6'h22, 6'h20,6'h20,6'h20,6'h20,6'h3E,
        6'h22,6'h36,6'h2A,6'h22,6'h22, 6'h22,6'h32,6'h2A,6'h26,6'h22,
        6'h1C,6'h22,6'h22,6'h22,6'h1C, 6'h3C,6'h22,6'h3C,6'h20,6'h20,
        6'h1C,6'h22,6'h22,6'h26,6'h1E, 6'h3C,6'h22,6'h3C,6'h24,6'h22,
        6'h1E,6'h20,6'h1C,6'h02,6'h3C, 6'h3E,6'h2A,6'h08,6'h08,6'h1C,
        6'h22,6'h22,6'h22,6'h22,6'h1C, 6'h22,6'h22,6'h14,6'h14,6'h08,
        6'h22,6'h22,6'h2A,6'h36,6'h22, 6'h22,6'h14,6'h08,6'h14,6'h22,
        6'h22,6'h14,6'h08,6'h08,6'h08, 6'h3E,6'h04,6'h08,6'h10,6'h3E,
        6'h00,6'h00,6'h00,6'h00,6'h00
    };

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [1:0] opcode      = '0;
    logic       big_font    = 1'b0;
    logic [1:0] align       = '0;
    logic [5:0] row         = '0;
    logic [5:0] column      = '0;
    logic [5:0] text_length = '0;
    logic [5:0] char_index  = '0;
    logic [6:0] char_code   = '0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] cell_char;

    logic [7:0] page_model [tgpb_pkg::PAGE_DEPTH];
    logic [7:0] expected_cells [$];

    bit idle_on = 1'b1;
    int cycle_count;
    int err_count;
    int checked_count;
    int n_items;
    int n_small;
    int n_big;
    int n_reads;
    int n_clears;
    int n_ignored;

    text_glyph_page_blitter_core u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .big_font    (big_font),
        .align       (align),
        .row         (row),
        .column      (column),
        .text_length (text_length),
        .char_index  (char_index),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_char   (cell_char)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= idle_on ? ($urandom_range(0, 99) >= 15) : 1'b1;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_cells.size() == 0)
                report_mismatch($sformatf("unexpected result cell_char=%02h", cell_char));
            else
            begin
                if (cell_char !== expected_cells[0])
                    report_mismatch($sformatf("cell_char %02h, expected %02h",
                                              cell_char, expected_cells[0]));
                void'(expected_cells.pop_front());
                checked_count++;
            end
        end
    end

    // page predictor
    function automatic void clear_model();
        foreach (page_model[i])
            page_model[i] = tgpb_pkg::CHAR_DOT;
    endfunction

    function automatic void write_cell(input int r, input int c, input logic [7:0] ch);
        if (r >= 0 && r < tgpb_pkg::PAGE_SIDE && c >= 0 && c < tgpb_pkg::PAGE_SIDE)
            page_model[r*tgpb_pkg::PAGE_SIDE + c] = ch;
    endfunction

    function automatic void apply_request(input page_req_t r);
        int top;
        int col;
        int len;
        int idx;
        int base;
        int glyph;
        logic [7:0] cell_val;
        top = int'(r.row) - 1;
        col = int'(r.column);
        len = int'(r.text_length);
        idx = int'(r.char_index);
        case (r.opcode)
            tgpb_pkg::OP_READ:
            begin
                cell_val = 8'h00;
                if (r.row >= 1 && r.row <= tgpb_pkg::PAGE_SIDE
                    && r.column >= 1 && r.column <= tgpb_pkg::PAGE_SIDE)
                    cell_val = page_model[top*tgpb_pkg::PAGE_SIDE + col - 1];
                expected_cells.push_back(cell_val);
            end
            tgpb_pkg::OP_CLEAR:
                clear_model();
            tgpb_pkg::OP_PLACE:
            begin
                if (!r.big_font)
                begin
                    case (r.align)
                        tgpb_pkg::ALIGN_LEFT:   base = 0;
                        tgpb_pkg::ALIGN_RIGHT:  base = tgpb_pkg::PAGE_SIDE - len;
                        tgpb_pkg::ALIGN_CENTER: base = tgpb_pkg::PAGE_SIDE/2 - len/2;
                        default:                base = col - 1;
                    endcase
                    if (r.char_code != tgpb_pkg::CHAR_SPACE)
                        write_cell(top, base + idx, {1'b0, r.char_code});
                end
                else
                begin
                    case (r.align)
                        tgpb_pkg::ALIGN_LEFT:   base = 0;
                        tgpb_pkg::ALIGN_RIGHT:  base = tgpb_pkg::PAGE_SIDE - 6*len;
                        tgpb_pkg::ALIGN_CENTER: base = tgpb_pkg::PAGE_SIDE/2 - 3*len;
                        default:                base = col - 1;
                    endcase
                    base += 6*idx;
                    glyph = -1;
                    if (r.char_code >= tgpb_pkg::CHAR_A && r.char_code <= tgpb_pkg::CHAR_Z)
                        glyph = int'(r.char_code - tgpb_pkg::CHAR_A);
                    else if (r.char_code == tgpb_pkg::CHAR_SPACE)
                        glyph = tgpb_pkg::GLYPH_COUNT - 1;
                    if (glyph >= 0)
                        for (int j = 0; j < tgpb_pkg::GLYPH_ROWS; j++)
                            for (int k = 0; k < tgpb_pkg::GLYPH_COLS; k++)
                                if (GLYPH_BITS[glyph*tgpb_pkg::GLYPH_ROWS + j][5-k])
                                    write_cell(top + j, base + k, tgpb_pkg::CHAR_STAR);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic page_req_t make_req(input logic [1:0] op, input logic big,
                                           input logic [1:0] al, input logic [5:0] rw,
                                           input logic [5:0] cl, input logic [5:0] ln,
                                           input logic [5:0] ix, input logic [6:0] ch);
        page_req_t r;
        r.opcode      = op;
        r.big_font    = big;
        r.align       = al;
        r.row         = rw;
        r.column      = cl;
        r.text_length = ln;
        r.char_index  = ix;
        r.char_code   = ch;
        return r;
    endfunction

    // called at a rising edge; returns at the edge where the request is taken
    task automatic issue_request(input page_req_t r);
        if (idle_on && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= r.opcode;
        big_font    <= r.big_font;
        align       <= r.align;
        row         <= r.row;
        column      <= r.column;
        text_length <= r.text_length;
        char_index  <= r.char_index;
        char_code   <= r.char_code;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        apply_request(r);
        case (r.opcode)
            tgpb_pkg::OP_PLACE: if (r.big_font) n_big++; else n_small++;
            tgpb_pkg::OP_READ:  n_reads++;
            tgpb_pkg::OP_CLEAR: n_clears++;
            default:            n_ignored++;
        endcase
        if (r.opcode != OP_UNUSED)
            n_items++;
    endtask

    task automatic read_cell(input logic [5:0] rw, input logic [5:0] cl);
        issue_request(make_req(tgpb_pkg::OP_READ, 1'b0, tgpb_pkg::ALIGN_LEFT, rw, cl,
                               6'd0, 6'd0, 7'd0));
    endtask

    function automatic logic [6:0] pick_char(input logic big);
        int p;
        p = $urandom_range(0, 99);
        if (p < 10)
            return 7'($urandom_range(0, 127));
        if (p < 20)
            return tgpb_pkg::CHAR_SPACE;
        if (big)
            return 7'($urandom_range(tgpb_pkg::CHAR_A, tgpb_pkg::CHAR_Z));
        return 7'($urandom_range(33, 126));
    endfunction

    task automatic test_reset_page();
        read_cell(6'd60, 6'd1);
        read_cell(6'd0, 6'd5);
        read_cell(6'd63, 6'd63);
    endtask

    task automatic test_small_font();
        issue_request(make_req(tgpb_pkg::OP_PLACE, 1'b0, tgpb_pkg::ALIGN_LEFT,
                               6'd1, 6'd0, 6'd1, 6'd0, tgpb_pkg::CHAR_A));
        issue_request(make_req(tgpb_pkg::OP_PLACE, 1'b0, tgpb_pkg::ALIGN_RIGHT,
                               6'd60, 6'd0, 6'd60, 6'd59, 7'h7A));
        // center with an odd long string starts left of the page
        issue_request(make_req(tgpb_pkg::OP_PLACE, 1'b0, tgpb_pkg::ALIGN_CENTER,
                               6'd2, 6'd0, 6'd63, 6'd0, 7'h7E));
        issue_request(make_req(tgpb_pkg::OP_PLACE, 1'b0, tgpb_pkg::ALIGN_CENTER,
                               6'd2, 6'd0, 6'd63, 6'd1, 7'h7F));
        issue_request(make_req(tgpb_pkg::OP_PLACE, 1'b0, tgpb_pkg::ALIGN_ABS,
                               6'd3, 6'd0, 6'd1, 6'd0, 7'h23));
        issue_request(make_req(tgpb_pkg::OP_PLACE, 1'b0, tgpb_pkg::ALIGN_ABS,
                               6'd1, 6'd1, 6'd1, 6'd0, tgpb_pkg::CHAR_SPACE));
        issue_request(make_req(tgpb_pkg::OP_PLACE, 1'b0, tgpb_pkg::ALIGN_LEFT,
                               6'd0, 6'd0, 6'd9, 6'd5, 7'h00));
        issue_request(make_req(tgpb_pkg::OP_PLACE, 1'b0, tgpb_pkg::ALIGN_ABS,
                               6'd4, 6'd1, 6'd63, 6'd63, 7'h40));
        read_cell(6'd1, 6'd1);
        read_cell(6'd60, 6'd60);
        read_cell(6'd2, 6'd1);
        read_cell(6'd3, 6'd1);
    endtask

    task automatic test_big_font();
        issue_request(make_req(tgpb_pkg::OP_PLACE, 1'b0, tgpb_pkg::ALIGN_ABS,
                               6'd1, 6'd2, 6'd1, 6'd0, 7'h71));
        issue_request(make_req(tgpb_pkg::OP_PLACE, 1'b1, tgpb_pkg::ALIGN_LEFT,
                               6'd1, 6'd0, 6'd1, 6'd0, 7'h57));
        issue_request(make_req(tgpb_pkg::OP_PLACE, 1'b1, tgpb_pkg::ALIGN_LEFT,
                               6'd1, 6'd0, 6'd1, 6'd0, tgpb_pkg::CHAR_SPACE));
        issue_request(make_req(tgpb_pkg::OP_PLACE, 1'b1, tgpb_pkg::ALIGN_ABS,
                               6'd58, 6'd57, 6'd1, 6'd0, tgpb_pkg::CHAR_Z));
        issue_request(make_req(tgpb_pkg::OP_PLACE, 1'b1, tgpb_pkg::ALIGN_ABS,
                               6'd10, 6'd0, 6'd1, 6'd0, 7'h48));
        issue_request(make_req(tgpb_pkg::OP_PLACE, 1'b1, tgpb_pkg::ALIGN_RIGHT,
                               6'd20, 6'd0, 6'd63, 6'd63, 7'h3F));
        read_cell(6'd1, 6'd1);
        read_cell(6'd1, 6'd2);
        read_cell(6'd58, 6'd60);
        read_cell(6'd10, 6'd4);
    endtask

    task automatic test_ignored_opcode();
        issue_request(make_req(OP_UNUSED, 1'b1, tgpb_pkg::ALIGN_ABS,
                               6'd1, 6'd1, 6'd1, 6'd0, tgpb_pkg::CHAR_A));
        read_cell(6'd1, 6'd1);
    endtask

    task automatic test_clear_page();
        issue_request(make_req(tgpb_pkg::OP_CLEAR, 1'b0, tgpb_pkg::ALIGN_LEFT,
                               6'd0, 6'd0, 6'd0, 6'd0, 7'd0));
        read_cell(6'd1, 6'd1);
    endtask

    task automatic test_random_traffic();
        page_req_t r;
        int start;
        int kind;
        int len;
        int cnt;
        logic big;
        logic [1:0] al;
        logic [5:0] rw;
        logic [5:0] cl;
        start = n_items;
        while (n_items - start < RANDOM_ITEMS)
        begin
            idle_on = !((n_items - start) >= 600 && (n_items - start) < 950);
            kind = $urandom_range(0, 99);
            big = 1'($urandom_range(0, 1));
            al  = 2'($urandom_range(0, 3));
            rw  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(1, 60));
            cl  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(1, 60));
            if (kind < 75)
            begin
                // well-formed string
                if ($urandom_range(0, 9) == 0)
                    len = big ? $urandom_range(11, 63) : $urandom_range(11, 60);
                else
                    len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    issue_request(make_req(tgpb_pkg::OP_PLACE, big, al, rw, cl, 6'(len),
                                           6'(i), pick_char(big)));
            end
            else if (kind < 88)
            begin
                // broken string: stray lengths and indexes
                cnt = $urandom_range(1, 6);
                for (int i = 0; i < cnt; i++)
                    issue_request(make_req(tgpb_pkg::OP_PLACE, big, al, rw, cl,
                                           6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                                           7'($urandom_range(0, 127))));
            end
            else
            begin
                r = make_req(2'($urandom_range(0, 3)), big, al, 6'($urandom_range(0, 63)),
                             6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                             6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)));
                issue_request(r);
            end
            cnt = $urandom_range(2, 6);
            for (int i = 0; i < cnt; i++)
                read_cell(rw + 6'($urandom_range(0, 4)),
                          ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                       : 6'($urandom_range(1, 60)));
        end
        idle_on = 1'b1;
    endtask

    task automatic test_final_readback();
        for (int i = 0; i < 24; i++)
            read_cell(6'($urandom_range(1, 60)), 6'($urandom_range(1, 60)));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        clear_model();
        test_reset_page();
        test_small_font();
        test_big_font();
        test_ignored_opcode();
        test_clear_page();
        test_random_traffic();
        test_final_readback();
        in_valid <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_cells.size() != 0)
            report_mismatch($sformatf("%0d read results never arrived", expected_cells.size()));
        $display("requests: %0d small places, %0d big places, %0d reads, %0d clears, %0d ignored",
                 n_small, n_big, n_reads, n_clears, n_ignored);
        $display("%0d cells read back and compared, %0d mismatches, %0d cycles",
                 checked_count, err_count, cycle_count);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
